// ===== src/dafd_pkg.sv =====
// Shared package for the dihedral angle unit: widths, payload types,
// CORDIC angle table and bit-length helpers. No dependencies.
package dafd_pkg;

    // Field and datapath widths
    localparam int CB    = 24;          // coordinate bits
    localparam int AFB   = 14;          // angle fraction bits
    localparam int VB    = 30;          // vector magnitude limit after scaling
    localparam int NB    = 40;          // normalized CORDIC operand bits
    localparam int ZF    = 30;          // angle accumulator fraction bits
    localparam int STEPS = 31;          // CORDIC iterations
    localparam int SW    = $clog2(STEPS);

    localparam int BW   = CB + 1;       // coordinate difference
    localparam int SVW  = VB + 1;       // scaled signed vector component
    localparam int PW   = 2 * SVW;      // product / cross component
    localparam int NMW  = PW - 1;       // cross component magnitude
    localparam int XW   = PW + 1;       // dot product
    localparam int BXW  = XW - 1;       // dot product magnitude
    localparam int SQW  = 2 * VB;       // square of a scaled magnitude
    localparam int YYW  = SQW + 2;      // sum of three squares
    localparam int RW   = YYW / 2;      // square root
    localparam int LW   = $clog2(BXW + 1);
    localparam int CW   = NB + 4;       // CORDIC x/y with growth and sign
    localparam int ZW   = ZF + 4;       // angle accumulator
    localparam int OW   = AFB + 2;      // output angle
    localparam int FSH  = ZF - AFB;
    localparam int RND  = (FSH == 0) ? 0 : (1 << (FSH - 1));

    localparam logic signed [ZW-1:0] PI_Z      = ZW'(33'd3373259426);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(33'd1686629713);

    typedef struct packed {
        logic signed [CB-1:0] p1_x;
        logic signed [CB-1:0] p1_y;
        logic signed [CB-1:0] p1_z;
        logic signed [CB-1:0] p2_x;
        logic signed [CB-1:0] p2_y;
        logic signed [CB-1:0] p2_z;
        logic signed [CB-1:0] p3_x;
        logic signed [CB-1:0] p3_y;
        logic signed [CB-1:0] p3_z;
        logic signed [CB-1:0] p4_x;
        logic signed [CB-1:0] p4_y;
        logic signed [CB-1:0] p4_z;
    } t_pts;

    typedef struct packed {
        logic [OW-1:0] torsion;
        logic          degenerate;
    } t_res;

    // Values that ride alongside the square root pipeline
    typedef struct packed {
        logic           neg;
        logic [BXW-1:0] bigx;
        logic           degen;
    } t_side;

    // Position of the highest set bit plus one
    function automatic logic [LW-1:0] bit_len(input logic [BXW-1:0] v);
        logic [LW-1:0] n;
        n = '0;
        for (int i = 0; i < BXW; i++) begin
            if (v[i]) begin
                n = LW'(i + 1);
            end
        end
        return n;
    endfunction

    // Right shift that brings a magnitude down to VB bits
    function automatic logic [LW-1:0] shrink_sh(input logic [BXW-1:0] m);
        logic [LW-1:0] n;
        n = bit_len(m);
        return (n > LW'(VB)) ? n - LW'(VB) : '0;
    endfunction

    // round(atan(2^-k) * 2^30)
    function automatic logic signed [ZW-1:0] atan_z(input logic [SW-1:0] k);
        case (k)
            5'd0:    return ZW'(843314857);
            5'd1:    return ZW'(497837829);
            5'd2:    return ZW'(263043837);
            5'd3:    return ZW'(133525159);
            5'd4:    return ZW'(67021687);
            5'd5:    return ZW'(33543516);
            5'd6:    return ZW'(16775851);
            5'd7:    return ZW'(8388437);
            5'd8:    return ZW'(4194283);
            5'd9:    return ZW'(2097149);
            5'd10:   return ZW'(1048576);
            5'd11:   return ZW'(524288);
            5'd12:   return ZW'(262144);
            5'd13:   return ZW'(131072);
            5'd14:   return ZW'(65536);
            5'd15:   return ZW'(32768);
            5'd16:   return ZW'(16384);
            5'd17:   return ZW'(8192);
            5'd18:   return ZW'(4096);
            5'd19:   return ZW'(2048);
            5'd20:   return ZW'(1024);
            5'd21:   return ZW'(512);
            5'd22:   return ZW'(256);
            5'd23:   return ZW'(128);
            5'd24:   return ZW'(64);
            5'd25:   return ZW'(32);
            5'd26:   return ZW'(16);
            5'd27:   return ZW'(8);
            5'd28:   return ZW'(4);
            5'd29:   return ZW'(2);
            5'd30:   return ZW'(1);
            default: return '0;
        endcase
    endfunction

endpackage

// ===== src/dafd_vec.sv =====
// Vector front end: bond vectors, plane normals, their dot and cross
// products and the squared cross length. Depends on dafd_pkg.
module dafd_vec (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  dafd_pkg::t_pts            i_pts,
    output logic                      o_valid,
    output logic [dafd_pkg::YYW-1:0]  o_yy,
    output dafd_pkg::t_side           o_side
);

    localparam int NS = 13;
    localparam int NXT1[3] = '{1, 2, 0};
    localparam int NXT2[3] = '{2, 0, 1};

    logic [NS-1:0] r_v;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    assign o_valid = r_v[NS-1];

    // Stage 1: bond vectors
    logic signed [dafd_pkg::CB-1:0] pts [4][3];
    logic signed [dafd_pkg::BW-1:0] r_b [3][3];

    assign pts[0][0] = i_pts.p1_x;
    assign pts[0][1] = i_pts.p1_y;
    assign pts[0][2] = i_pts.p1_z;
    assign pts[1][0] = i_pts.p2_x;
    assign pts[1][1] = i_pts.p2_y;
    assign pts[1][2] = i_pts.p2_z;
    assign pts[2][0] = i_pts.p3_x;
    assign pts[2][1] = i_pts.p3_y;
    assign pts[2][2] = i_pts.p3_z;
    assign pts[3][0] = i_pts.p4_x;
    assign pts[3][1] = i_pts.p4_y;
    assign pts[3][2] = i_pts.p4_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                for (int c = 0; c < 3; c++) begin
                    r_b[j][c] <= dafd_pkg::BW'(pts[j+1][c]) - dafd_pkg::BW'(pts[j][c]);
                end
            end
        end
    end

    // Stage 2: magnitudes and scale shift of each bond vector
    logic [dafd_pkg::BW-1:0]  b_mag [3][3];
    logic [dafd_pkg::BW-1:0]  b_or  [3];
    logic [dafd_pkg::BW-1:0]  r_bm  [3][3];
    logic                     r_bs  [3][3];
    logic [dafd_pkg::LW-1:0]  r_bsh [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            b_or[j] = '0;
            for (int c = 0; c < 3; c++) begin
                b_mag[j][c] = r_b[j][c][dafd_pkg::BW-1] ? dafd_pkg::BW'(-r_b[j][c])
                                                        : dafd_pkg::BW'(r_b[j][c]);
                b_or[j] = b_or[j] | b_mag[j][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_bsh[j] <= dafd_pkg::shrink_sh(dafd_pkg::BXW'(b_or[j]));
                for (int c = 0; c < 3; c++) begin
                    r_bm[j][c] <= b_mag[j][c];
                    r_bs[j][c] <= r_b[j][c][dafd_pkg::BW-1];
                end
            end
        end
    end

    // Stage 3: apply scale shift toward zero
    logic [dafd_pkg::BW-1:0]         b_u  [3][3];
    logic signed [dafd_pkg::SVW-1:0] r_bv [3][3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int c = 0; c < 3; c++) begin
                b_u[j][c] = r_bm[j][c] >> r_bsh[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                for (int c = 0; c < 3; c++) begin
                    r_bv[j][c] <= r_bs[j][c] ? -dafd_pkg::SVW'(b_u[j][c])
                                             : dafd_pkg::SVW'(b_u[j][c]);
                end
            end
        end
    end

    // Stage 4: cross product terms for both normals
    logic signed [dafd_pkg::PW-1:0] r_pa [2][3];
    logic signed [dafd_pkg::PW-1:0] r_pb [2][3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < 2; n++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pa[n][c] <= dafd_pkg::PW'(r_bv[n][NXT1[c]])
                                * dafd_pkg::PW'(r_bv[n+1][NXT2[c]]);
                    r_pb[n][c] <= dafd_pkg::PW'(r_bv[n][NXT2[c]])
                                * dafd_pkg::PW'(r_bv[n+1][NXT1[c]]);
                end
            end
        end
    end

    // Stage 5: normals
    logic signed [dafd_pkg::PW-1:0] r_n [2][3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < 2; n++) begin
                for (int c = 0; c < 3; c++) begin
                    r_n[n][c] <= r_pa[n][c] - r_pb[n][c];
                end
            end
        end
    end

    // Stage 6: normal magnitudes, scale shift, degenerate check
    logic [dafd_pkg::NMW-1:0] n_mag [2][3];
    logic [dafd_pkg::NMW-1:0] n_or  [2];
    logic [dafd_pkg::NMW-1:0] r_nm  [2][3];
    logic                     r_ns  [2][3];
    logic [dafd_pkg::LW-1:0]  r_nsh [2];
    logic                     r_dg6;

    always_comb begin
        for (int n = 0; n < 2; n++) begin
            n_or[n] = '0;
            for (int c = 0; c < 3; c++) begin
                n_mag[n][c] = r_n[n][c][dafd_pkg::PW-1] ? dafd_pkg::NMW'(-r_n[n][c])
                                                        : dafd_pkg::NMW'(r_n[n][c]);
                n_or[n] = n_or[n] | n_mag[n][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dg6 <= (n_or[0] == '0) || (n_or[1] == '0);
            for (int n = 0; n < 2; n++) begin
                r_nsh[n] <= dafd_pkg::shrink_sh(dafd_pkg::BXW'(n_or[n]));
                for (int c = 0; c < 3; c++) begin
                    r_nm[n][c] <= n_mag[n][c];
                    r_ns[n][c] <= r_n[n][c][dafd_pkg::PW-1];
                end
            end
        end
    end

    // Stage 7: scaled normals
    logic [dafd_pkg::NMW-1:0]        n_u  [2][3];
    logic signed [dafd_pkg::SVW-1:0] r_nv [2][3];
    logic                            r_dg7;

    always_comb begin
        for (int n = 0; n < 2; n++) begin
            for (int c = 0; c < 3; c++) begin
                n_u[n][c] = r_nm[n][c] >> r_nsh[n];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dg7 <= r_dg6;
            for (int n = 0; n < 2; n++) begin
                for (int c = 0; c < 3; c++) begin
                    r_nv[n][c] <= r_ns[n][c] ? -dafd_pkg::SVW'(n_u[n][c])
                                             : dafd_pkg::SVW'(n_u[n][c]);
                end
            end
        end
    end

    // Stage 8: dot and cross terms of the normals
    logic signed [dafd_pkg::PW-1:0] r_pd [3];
    logic signed [dafd_pkg::PW-1:0] r_qa [3];
    logic signed [dafd_pkg::PW-1:0] r_qb [3];
    logic                           r_dg8;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dg8 <= r_dg7;
            for (int c = 0; c < 3; c++) begin
                r_pd[c] <= dafd_pkg::PW'(r_nv[0][c]) * dafd_pkg::PW'(r_nv[1][c]);
                r_qa[c] <= dafd_pkg::PW'(r_nv[0][NXT1[c]]) * dafd_pkg::PW'(r_nv[1][NXT2[c]]);
                r_qb[c] <= dafd_pkg::PW'(r_nv[0][NXT2[c]]) * dafd_pkg::PW'(r_nv[1][NXT1[c]]);
            end
        end
    end

    // Stage 9: dot product and cross vector
    logic signed [dafd_pkg::XW-1:0] r_x;
    logic signed [dafd_pkg::PW-1:0] r_w [3];
    logic                           r_dg9;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dg9 <= r_dg8;
            r_x   <= dafd_pkg::XW'(r_pd[0]) + dafd_pkg::XW'(r_pd[1]) + dafd_pkg::XW'(r_pd[2]);
            for (int c = 0; c < 3; c++) begin
                r_w[c] <= r_qa[c] - r_qb[c];
            end
        end
    end

    // Stage 10: cross vector magnitudes and its scale shift
    logic [dafd_pkg::NMW-1:0]       w_mag [3];
    logic [dafd_pkg::NMW-1:0]       w_or;
    logic [dafd_pkg::NMW-1:0]       r_wm  [3];
    logic [dafd_pkg::LW-1:0]        r_sw;
    logic signed [dafd_pkg::XW-1:0] r_x10;
    logic                           r_dg10;

    always_comb begin
        w_or = '0;
        for (int c = 0; c < 3; c++) begin
            w_mag[c] = r_w[c][dafd_pkg::PW-1] ? dafd_pkg::NMW'(-r_w[c])
                                              : dafd_pkg::NMW'(r_w[c]);
            w_or = w_or | w_mag[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dg10 <= r_dg9;
            r_x10  <= r_x;
            r_sw   <= dafd_pkg::shrink_sh(dafd_pkg::BXW'(w_or));
            for (int c = 0; c < 3; c++) begin
                r_wm[c] <= w_mag[c];
            end
        end
    end

    // Stage 11: scaled cross magnitudes; dot magnitude takes the same shift
    logic [dafd_pkg::BXW-1:0] x_mag;
    logic [dafd_pkg::VB-1:0]  r_wu [3];
    dafd_pkg::t_side          r_sd11;

    always_comb begin
        x_mag = r_x10[dafd_pkg::XW-1] ? dafd_pkg::BXW'(-r_x10) : dafd_pkg::BXW'(r_x10);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd11.neg   <= r_x10[dafd_pkg::XW-1];
            r_sd11.bigx  <= x_mag >> r_sw;
            r_sd11.degen <= r_dg10;
            for (int c = 0; c < 3; c++) begin
                r_wu[c] <= dafd_pkg::VB'(r_wm[c] >> r_sw);
            end
        end
    end

    // Stage 12: squares
    logic [dafd_pkg::SQW-1:0] r_sq [3];
    dafd_pkg::t_side          r_sd12;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd12 <= r_sd11;
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= dafd_pkg::SQW'(r_wu[c]) * dafd_pkg::SQW'(r_wu[c]);
            end
        end
    end

    // Stage 13: squared cross length
    logic [dafd_pkg::YYW-1:0] r_yy;
    dafd_pkg::t_side          r_sd13;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd13 <= r_sd12;
            r_yy   <= dafd_pkg::YYW'(r_sq[0]) + dafd_pkg::YYW'(r_sq[1])
                    + dafd_pkg::YYW'(r_sq[2]);
        end
    end

    assign o_yy   = r_yy;
    assign o_side = r_sd13;

endmodule

// ===== src/dafd_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a
// sideband that travels alongside. Depends on dafd_pkg.
module dafd_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [dafd_pkg::YYW-1:0] i_yy,
    input  dafd_pkg::t_side          i_side,
    output logic                     o_valid,
    output logic [dafd_pkg::RW-1:0]  o_root,
    output dafd_pkg::t_side          o_side
);

    localparam int RW  = dafd_pkg::RW;
    localparam int RMW = RW + 2;

    logic [RW-1:0]            r_v;
    logic [dafd_pkg::YYW-1:0] r_rad  [RW];
    logic [RMW-1:0]           r_rem  [RW];
    logic [RW-1:0]            r_root [RW];
    dafd_pkg::t_side          r_sd   [RW];

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RW-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [dafd_pkg::YYW-1:0] p_rad;
        logic [RMW-1:0]           p_rem;
        logic [RW-1:0]            p_root;
        dafd_pkg::t_side          p_sd;
        logic [RMW-1:0]           pre;
        logic [RMW-1:0]           trial;
        logic                     ge;

        if (k == 0) begin : g_first
            assign p_rad  = i_yy;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_sd   = i_side;
        end else begin : g_next
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_sd   = r_sd[k-1];
        end

        // Bring down two radicand bits and try to subtract 4*root+1
        always_comb begin
            pre   = {p_rem[RMW-3:0], p_rad[dafd_pkg::YYW-1 -: 2]};
            trial = {p_root, 2'b01};
            ge    = (pre >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= p_rad << 2;
                r_rem[k]  <= ge ? pre - trial : pre;
                r_root[k] <= {p_root[RW-2:0], ge};
                r_sd[k]   <= p_sd;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_sd[RW-1];

endmodule

// ===== src/dafd_cordic.sv =====
// Operand normalization, pipelined vectoring CORDIC for atan2, then clamp
// and rounding to the output angle format. Depends on dafd_pkg.
module dafd_cordic (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [dafd_pkg::RW-1:0] i_root,
    input  dafd_pkg::t_side         i_side,
    output logic                    o_valid,
    output dafd_pkg::t_res          o_res
);

    localparam int STEPS = dafd_pkg::STEPS;
    localparam int NS    = STEPS + 3;
    localparam int CW    = dafd_pkg::CW;
    localparam int ZW    = dafd_pkg::ZW;
    localparam int NB    = dafd_pkg::NB;
    localparam int LW    = dafd_pkg::LW;
    localparam int BXW   = dafd_pkg::BXW;

    logic [NS-1:0] r_v;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // Stage A: common bit length of both operands
    logic [BXW-1:0] r_ax;
    logic [BXW-1:0] r_ay;
    logic [LW-1:0]  r_alen;
    logic           r_aneg;
    logic           r_adg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= i_side.bigx;
            r_ay   <= BXW'(i_root);
            r_alen <= dafd_pkg::bit_len(i_side.bigx | BXW'(i_root));
            r_aneg <= i_side.neg;
            r_adg  <= i_side.degen;
        end
    end

    // Stage B: normalize to NB bits, pre-rotate when the dot product is negative
    logic [LW-1:0] up_sh;
    logic [LW-1:0] dn_sh;
    logic [NB-1:0] nx;
    logic [NB-1:0] ny;

    logic signed [CW-1:0] r_cx [STEPS+1];
    logic signed [CW-1:0] r_cy [STEPS+1];
    logic signed [ZW-1:0] r_z  [STEPS+1];
    logic                 r_dg [STEPS+1];

    always_comb begin
        up_sh = LW'(NB) - r_alen;
        dn_sh = r_alen - LW'(NB);
        if (r_alen > LW'(NB)) begin
            nx = NB'(r_ax >> dn_sh);
            ny = NB'(r_ay >> dn_sh);
        end else begin
            nx = NB'(r_ax << up_sh);
            ny = NB'(r_ay << up_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dg[0] <= r_adg;
            if (r_aneg) begin
                r_cx[0] <= CW'(ny);
                r_cy[0] <= CW'(nx);
                r_z[0]  <= dafd_pkg::HALF_PI_Z;
            end else begin
                r_cx[0] <= CW'(nx);
                r_cy[0] <= CW'(ny);
                r_z[0]  <= '0;
            end
        end
    end

    // CORDIC iterations: drive y toward zero, accumulate angle
    for (genvar k = 0; k < STEPS; k++) begin : g_iter
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] n_cx;
        logic signed [CW-1:0] n_cy;
        logic signed [ZW-1:0] n_z;

        always_comb begin
            sx = r_cx[k] >>> k;
            sy = r_cy[k] >>> k;
            if (r_cy[k] > 0) begin
                n_cx = r_cx[k] + sy;
                n_cy = r_cy[k] - sx;
                n_z  = r_z[k] + dafd_pkg::atan_z(dafd_pkg::SW'(k));
            end else if (r_cy[k] < 0) begin
                n_cx = r_cx[k] - sy;
                n_cy = r_cy[k] + sx;
                n_z  = r_z[k] - dafd_pkg::atan_z(dafd_pkg::SW'(k));
            end else begin
                n_cx = r_cx[k];
                n_cy = r_cy[k];
                n_z  = r_z[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cx[k+1] <= n_cx;
                r_cy[k+1] <= n_cy;
                r_z[k+1]  <= n_z;
                r_dg[k+1] <= r_dg[k];
            end
        end
    end

    // Output stage: clamp to [0, pi], round half up, force zero when degenerate
    logic [ZW-1:0]  z_clamp;
    logic [ZW-1:0]  z_round;
    dafd_pkg::t_res n_res;
    dafd_pkg::t_res r_res;

    always_comb begin
        if (r_z[STEPS] < 0) begin
            z_clamp = '0;
        end else if (r_z[STEPS] > dafd_pkg::PI_Z) begin
            z_clamp = dafd_pkg::PI_Z;
        end else begin
            z_clamp = r_z[STEPS];
        end
        z_round          = z_clamp + ZW'(dafd_pkg::RND);
        n_res.degenerate = r_dg[STEPS];
        n_res.torsion    = r_dg[STEPS] ? '0
                                       : dafd_pkg::OW'(z_round >> dafd_pkg::FSH);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_res   = r_res;

endmodule

// ===== src/dihedral_angle_from_distances_unit.sv =====
// Each input beat passes 13 vector stages, 31 square root stages
// and 34 normalize/CORDIC/rounding stages on the way to its result beat.
// Throughput: one beat per cycle; a stalled result freezes the whole pipe.
// Reset (i_rst_n low, synchronous) clears the valid bits only.
// Top level of the dihedral angle unit; uses dafd_pkg, dafd_vec,
// dafd_isqrt and dafd_cordic.
module dihedral_angle_from_distances_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dafd_pkg::t_pts  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output dafd_pkg::t_res  o_out_data
);

    logic                     en;
    logic                     vec_valid;
    logic [dafd_pkg::YYW-1:0] vec_yy;
    dafd_pkg::t_side          vec_side;
    logic                     sq_valid;
    logic [dafd_pkg::RW-1:0]  sq_root;
    dafd_pkg::t_side          sq_side;

    // Advance the pipe unless a result beat is waiting
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    dafd_vec u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_pts   (i_in_data),
        .o_valid (vec_valid),
        .o_yy    (vec_yy),
        .o_side  (vec_side)
    );

    dafd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (vec_valid),
        .i_yy    (vec_yy),
        .i_side  (vec_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    dafd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_valid (o_out_valid),
        .o_res   (o_out_data)
    );

endmodule
